### design/cau_pkg.sv
package cau_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int SumWidth  = ProdWidth + 1;
   localparam int NumWidth  = ProdWidth + FracBits;
   localparam int DivSteps  = DataWidth;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   typedef struct packed {
      logic [DataWidth-1:0] re;
      logic [DataWidth-1:0] im;
      logic [1:0]           status;
   } result_type;

   typedef struct packed {
      logic [DataWidth-1:0] val;
      logic                 sat;
   } sat_type;

   typedef struct packed {
      logic                        valid;
      op_type                      op;
      logic signed [ProdWidth-1:0] p_rr;
      logic signed [ProdWidth-1:0] p_ii;
      logic signed [ProdWidth-1:0] p_ri;
      logic signed [ProdWidth-1:0] p_ir;
      logic signed [ProdWidth-1:0] sq_r;
      logic signed [ProdWidth-1:0] sq_i;
      logic signed [SumWidth-1:0]  lin_re;
      logic signed [SumWidth-1:0]  lin_im;
   } mult_stage_type;

   typedef struct packed {
      logic                        valid;
      op_type                      op;
      logic signed [SumWidth-1:0]  mul_re;
      logic signed [SumWidth-1:0]  mul_im;
      logic signed [SumWidth-1:0]  num_re;
      logic signed [SumWidth-1:0]  num_im;
      logic [ProdWidth-1:0]        den;
      logic signed [SumWidth-1:0]  lin_re;
      logic signed [SumWidth-1:0]  lin_im;
   } sum_stage_type;

   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 div_zero;
      logic [ProdWidth-1:0] den;
      logic [ProdWidth-1:0] rem_re;
      logic [ProdWidth-1:0] rem_im;
      logic [DataWidth-1:0] sh_re;
      logic [DataWidth-1:0] sh_im;
      logic                 neg_re;
      logic                 neg_im;
      logic                 ovf_re;
      logic                 ovf_im;
      result_type           res;
   } div_stage_type;

   typedef struct packed {
      logic [ProdWidth-1:0] rem;
      logic [DataWidth-1:0] sh;
   } div_lane_type;

   function automatic logic [ProdWidth-1:0] abs_mag(input logic signed [SumWidth-1:0] v);
      logic [SumWidth-1:0] m;
      m = v[SumWidth-1] ? $unsigned(-v) : $unsigned(v);
      return m[ProdWidth-1:0];
   endfunction

   // clamp a sign-magnitude value to the signed range
   function automatic sat_type sat_mag(input logic [ProdWidth-1:0] mag, input logic neg);
      logic [ProdWidth-1:0] lim;
      logic [ProdWidth-1:0] m;
      sat_type              r;
      lim = {{(ProdWidth-DataWidth){1'b0}}, 1'b1, {(DataWidth-1){1'b0}}};
      if (!neg) begin
         lim = lim - ProdWidth'(1);
      end
      m     = mag;
      r.sat = 1'b0;
      if (mag > lim) begin
         m     = lim;
         r.sat = 1'b1;
      end
      r.val = neg ? (DataWidth'(0) - m[DataWidth-1:0]) : m[DataWidth-1:0];
      return r;
   endfunction

   // one restoring step: bring in the next numerator bit, shift the quotient bit in
   function automatic div_lane_type div_step(input div_lane_type x,
                                             input logic [ProdWidth-1:0] den);
      logic [ProdWidth:0] rem2;
      logic [ProdWidth:0] diff;
      div_lane_type       r;
      rem2 = {x.rem, x.sh[DataWidth-1]};
      diff = rem2 - {1'b0, den};
      if (!diff[ProdWidth]) begin
         r.rem = diff[ProdWidth-1:0];
         r.sh  = {x.sh[DataWidth-2:0], 1'b1};
      end else begin
         r.rem = rem2[ProdWidth-1:0];
         r.sh  = {x.sh[DataWidth-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### design/complex_arithmetic_unit_core.sv
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide and
// conjugate. Fully pipelined: one item per cycle in and out while the output is
// not stalled, through one multiply stage, one sum stage, one setup stage, 32
// restoring divider stages and the output register. The divider depth sets the
// latency for every opcode. A stalled output holds the whole pipeline in place.
module complex_arithmetic_unit_core
   import cau_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_op,
   input  logic [DataWidth-1:0] req_a_re,
   input  logic [DataWidth-1:0] req_a_im,
   input  logic [DataWidth-1:0] req_b_re,
   input  logic [DataWidth-1:0] req_b_im,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DataWidth-1:0] rsp_res_re,
   output logic [DataWidth-1:0] rsp_res_im,
   output logic [1:0]           rsp_status
);

   mult_stage_type s1_ff, s1_in;
   sum_stage_type  s2_ff, s2_in;
   div_stage_type  div_ff [0:DivSteps];
   div_stage_type  div_in [0:DivSteps];
   logic           out_valid_ff, out_valid_in;
   result_type     out_ff, out_in;
   logic           adv;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: products and linear ops
   always_comb begin
      logic signed [DataWidth-1:0] ar, ai, br, bi;
      ar = $signed(req_a_re);
      ai = $signed(req_a_im);
      br = $signed(req_b_re);
      bi = $signed(req_b_im);
      s1_in.valid = req_valid;
      s1_in.op    = op_type'(req_op);
      s1_in.p_rr  = ProdWidth'(ar) * ProdWidth'(br);
      s1_in.p_ii  = ProdWidth'(ai) * ProdWidth'(bi);
      s1_in.p_ri  = ProdWidth'(ar) * ProdWidth'(bi);
      s1_in.p_ir  = ProdWidth'(ai) * ProdWidth'(br);
      s1_in.sq_r  = ProdWidth'(br) * ProdWidth'(br);
      s1_in.sq_i  = ProdWidth'(bi) * ProdWidth'(bi);
      case (op_type'(req_op))
         OP_ADD: begin
            s1_in.lin_re = SumWidth'(ar) + SumWidth'(br);
            s1_in.lin_im = SumWidth'(ai) + SumWidth'(bi);
         end
         OP_SUB: begin
            s1_in.lin_re = SumWidth'(ar) - SumWidth'(br);
            s1_in.lin_im = SumWidth'(ai) - SumWidth'(bi);
         end
         OP_CONJ: begin
            s1_in.lin_re = SumWidth'(ar);
            s1_in.lin_im = -SumWidth'(ai);
         end
         default: begin
            s1_in.lin_re = '0;
            s1_in.lin_im = '0;
         end
      endcase
   end

   // stage 2: sums of products
   always_comb begin
      s2_in.valid  = s1_ff.valid;
      s2_in.op     = s1_ff.op;
      s2_in.mul_re = SumWidth'(s1_ff.p_rr) - SumWidth'(s1_ff.p_ii);
      s2_in.mul_im = SumWidth'(s1_ff.p_ri) + SumWidth'(s1_ff.p_ir);
      s2_in.num_re = SumWidth'(s1_ff.p_rr) + SumWidth'(s1_ff.p_ii);
      s2_in.num_im = SumWidth'(s1_ff.p_ir) - SumWidth'(s1_ff.p_ri);
      s2_in.den    = $unsigned(s1_ff.sq_r) + $unsigned(s1_ff.sq_i);
      s2_in.lin_re = s1_ff.lin_re;
      s2_in.lin_im = s1_ff.lin_im;
   end

   // stage 3: finish non-divide ops, set up the divider
   always_comb begin
      logic [NumWidth-1:0]  nr, ni;
      logic [ProdWidth-1:0] mr, mi;
      sat_type              sr, si;
      nr = {abs_mag(s2_ff.num_re), {FracBits{1'b0}}};
      ni = {abs_mag(s2_ff.num_im), {FracBits{1'b0}}};
      mr = abs_mag(s2_ff.mul_re) >> FracBits;
      mi = abs_mag(s2_ff.mul_im) >> FracBits;
      div_in[0].valid    = s2_ff.valid;
      div_in[0].is_div   = (s2_ff.op == OP_DIV);
      div_in[0].div_zero = (s2_ff.den == '0);
      div_in[0].den      = s2_ff.den;
      div_in[0].rem_re   = ProdWidth'(nr[NumWidth-1:DataWidth]);
      div_in[0].rem_im   = ProdWidth'(ni[NumWidth-1:DataWidth]);
      div_in[0].sh_re    = nr[DataWidth-1:0];
      div_in[0].sh_im    = ni[DataWidth-1:0];
      div_in[0].neg_re   = s2_ff.num_re[SumWidth-1];
      div_in[0].neg_im   = s2_ff.num_im[SumWidth-1];
      // quotient needs more than DataWidth bits
      div_in[0].ovf_re   = ProdWidth'(nr[NumWidth-1:DataWidth]) >= s2_ff.den;
      div_in[0].ovf_im   = ProdWidth'(ni[NumWidth-1:DataWidth]) >= s2_ff.den;
      case (s2_ff.op)
         OP_MUL: begin
            sr = sat_mag(mr, s2_ff.mul_re[SumWidth-1]);
            si = sat_mag(mi, s2_ff.mul_im[SumWidth-1]);
         end
         default: begin
            sr = sat_mag(abs_mag(s2_ff.lin_re), s2_ff.lin_re[SumWidth-1]);
            si = sat_mag(abs_mag(s2_ff.lin_im), s2_ff.lin_im[SumWidth-1]);
         end
      endcase
      div_in[0].res.re     = sr.val;
      div_in[0].res.im     = si.val;
      div_in[0].res.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
   end

   // divider stages
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      always_comb begin
         div_lane_type lr, li;
         lr = div_step({div_ff[k].rem_re, div_ff[k].sh_re}, div_ff[k].den);
         li = div_step({div_ff[k].rem_im, div_ff[k].sh_im}, div_ff[k].den);
         div_in[k+1]        = div_ff[k];
         div_in[k+1].rem_re = lr.rem;
         div_in[k+1].sh_re  = lr.sh;
         div_in[k+1].rem_im = li.rem;
         div_in[k+1].sh_im  = li.sh;
      end
   end

   // output stage
   always_comb begin
      logic [ProdWidth-1:0] qr, qi;
      sat_type              sr, si;
      qr = div_ff[DivSteps].ovf_re ? '1 : ProdWidth'(div_ff[DivSteps].sh_re);
      qi = div_ff[DivSteps].ovf_im ? '1 : ProdWidth'(div_ff[DivSteps].sh_im);
      sr = sat_mag(qr, div_ff[DivSteps].neg_re);
      si = sat_mag(qi, div_ff[DivSteps].neg_im);
      out_valid_in = div_ff[DivSteps].valid;
      if (!div_ff[DivSteps].is_div) begin
         out_in = div_ff[DivSteps].res;
      end else if (div_ff[DivSteps].div_zero) begin
         out_in.re     = '0;
         out_in.im     = '0;
         out_in.status = ST_DIV_ZERO;
      end else begin
         out_in.re     = sr.val;
         out_in.im     = si.val;
         out_in.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= DivSteps; k++) begin
            div_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k <= DivSteps; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_res_re = out_ff.re;
   assign rsp_res_im = out_ff.im;
   assign rsp_status = out_ff.status;

`ifndef SYNTHESIS
   localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

   a_div_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIV_ZERO |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero result not cleared");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAT |->
         rsp_res_re == MaxVal || rsp_res_re == MinVal ||
         rsp_res_im == MaxVal || rsp_res_im == MinVal)
      else $error("saturation flagged without a clamped part");
`endif

endmodule
